[rtl/core/lsf_pkg.sv]
`timescale 1ns / 1ps

package lsf_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_DIM_W      = 11;
    localparam int WEIGHT_W       = 16;
    localparam int FRAC_W         = 16;
    localparam int NUM_CFG        = 5;
    localparam int CFG_IDX_W      = $clog2(NUM_CFG);
    localparam int APB_AW         = CFG_IDX_W + 2;
    localparam int APB_DW         = 32;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = CFG_DIM_W'(256);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = CFG_DIM_W'(256);
    localparam logic [WEIGHT_W-1:0]  CENTER_RST = WEIGHT_W'(9169);
    localparam logic [WEIGHT_W-1:0]  EDGE_RST   = WEIGHT_W'(7710);
    localparam logic [WEIGHT_W-1:0]  CORNER_RST = WEIGHT_W'(6382);

    // line store word holds the two previous rows: {upper, middle}
    localparam int LS_W          = 2 * PIX_W;
    localparam int SUM_W         = PIX_W + 2;
    localparam int PC_W          = PIX_W + WEIGHT_W;
    localparam int PS_W          = SUM_W + WEIGHT_W;
    localparam int ACC_W         = PS_W + 2;
    localparam int NUM_WIN_CELLS = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = CFG_IDX_W'(0),
        CFG_IMAGE_HEIGHT  = CFG_IDX_W'(1),
        CFG_CENTER_WEIGHT = CFG_IDX_W'(2),
        CFG_EDGE_WEIGHT   = CFG_IDX_W'(3),
        CFG_CORNER_WEIGHT = CFG_IDX_W'(4)
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic emit;
        logic left_en;
        logic right_en;
        logic top_en;
        logic bot_en;
        logic last;
    } t_tap_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [SUM_W-1:0] edge_sum;
        logic [SUM_W-1:0] corner_sum;
        logic             last;
    } t_mac_in;

endpackage

[rtl/core/lsf_in_if.sv]
`timescale 1ns / 1ps

interface lsf_in_if;
    import lsf_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

[rtl/core/lsf_out_if.sv]
`timescale 1ns / 1ps

interface lsf_out_if;
    import lsf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[rtl/core/lsf_ram.sv]
`timescale 1ns / 1ps

module lsf_ram #(
    parameter int WIDTH = lsf_pkg::LS_W,
    parameter int DEPTH = lsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/lsf_cell.sv]
`timescale 1ns / 1ps

module lsf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  lsf_pkg::t_column  i_col,
    output lsf_pkg::t_column  o_col
);
    import lsf_pkg::*;

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

[rtl/core/lsf_mac.sv]
`timescale 1ns / 1ps

module lsf_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  lsf_pkg::t_mac_in               i_data,
    input  logic [lsf_pkg::WEIGHT_W-1:0]   i_center_weight,
    input  logic [lsf_pkg::WEIGHT_W-1:0]   i_edge_weight,
    input  logic [lsf_pkg::WEIGHT_W-1:0]   i_corner_weight,
    lsf_out_if.source                      o_pix
);
    import lsf_pkg::*;

    logic             r_c_valid;
    logic [PC_W-1:0]  r_c_pc;
    logic [PS_W-1:0]  r_c_pe;
    logic [PS_W-1:0]  r_c_pk;
    logic             r_c_last;

    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pixel;
    logic             r_o_last;

    logic             out_adv;
    logic             c_load;
    logic [ACC_W-1:0] acc;
    logic [PIX_W-1:0] n_pixel;

    assign out_adv = !r_o_valid || o_pix.ready;
    assign c_load  = !r_c_valid || out_adv;
    assign o_ready = c_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_load) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load && i_valid) begin
            r_c_pc   <= PC_W'(i_data.center) * PC_W'(i_center_weight);
            r_c_pe   <= PS_W'(i_data.edge_sum) * PS_W'(i_edge_weight);
            r_c_pk   <= PS_W'(i_data.corner_sum) * PS_W'(i_corner_weight);
            r_c_last <= i_data.last;
        end
    end

    always_comb begin
        acc = ACC_W'(r_c_pc) + ACC_W'(r_c_pe) + ACC_W'(r_c_pk);
        if (|acc[ACC_W-1:FRAC_W+PIX_W]) begin
            n_pixel = '1;
        end else begin
            n_pixel = acc[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_c_valid) begin
            r_o_pixel <= n_pixel;
            r_o_last  <= r_c_last;
        end
    end

    assign o_pix.valid     = r_o_valid;
    assign o_pix.pixel_out = r_o_pixel;
    assign o_pix.frame_end = r_o_last;
endmodule

[rtl/core/log_stencil_filter_3x3.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                      Transaction when
// i_pix     in         mode, pixel_in               i_pix.valid && i_pix.ready
// o_pix     out        pixel_out, frame_end         o_pix.valid && o_pix.ready
// APB       in/out     psel/penable/pwrite/paddr    psel && penable && pwrite
//
// One pixel per cycle while the output is not stalled; the transaction that completes
// a window moves through the window, MAC product and output registers in turn.
// Line store is one registered-read RAM (both past rows per column), read at accept.
// Synchronous active-low reset clears control and window; the RAM is not cleared.
// Stalls back up from the output register; items with no result drain freely.

module log_stencil_filter_3x3 #(
    parameter int MAX_WIDTH  = lsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lsf_in_if.sink                      i_pix,
    lsf_out_if.source                   o_pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsf_pkg::APB_AW-1:0]  paddr,
    input  logic [lsf_pkg::APB_DW-1:0]  pwdata,
    output logic [lsf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import lsf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int WXW = (WCW > CFG_DIM_W) ? WCW : CFG_DIM_W;
    localparam int RW  = $clog2(MAX_HEIGHT + 3);
    localparam int HXW = (RW > CFG_DIM_W) ? RW : CFG_DIM_W;

    // configuration
    logic [CFG_DIM_W-1:0] r_image_width;
    logic [CFG_DIM_W-1:0] r_image_height;
    logic [WEIGHT_W-1:0]  r_center_weight;
    logic [WEIGHT_W-1:0]  r_edge_weight;
    logic [WEIGHT_W-1:0]  r_corner_weight;
    logic                 cfg_wr;
    logic                 geom_wr;
    t_cfg_idx             cfg_idx;

    // geometry
    logic [WXW-1:0] w_raw;
    logic [HXW-1:0] h_raw;
    logic [WCW-1:0] w_eff;
    logic [RW-1:0]  h_eff;

    // position and accept stage
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  n_row;
    logic [CW-1:0]  n_col;
    logic [WCW-1:0] col_inc;
    logic [RW-1:0]  row_inc;
    logic           col_zero;
    logic           e1;
    logic           e2;
    t_tap_ctl       tap;
    logic           accept;
    logic           in_ready;
    logic [PIX_W-1:0] x_val;

    // window stage
    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_x;
    logic [CW-1:0]    r_b_col;
    t_tap_ctl         r_b_ctl;
    logic             r_b_fwd;
    logic [LS_W-1:0]  r_b_fwd_data;
    logic [LS_W-1:0]  ram_q;
    logic [LS_W-1:0]  ls_word;
    logic [LS_W-1:0]  wr_data;
    logic             b_adv;
    logic             b_fire;
    t_column          col_n;
    t_column          cell_in  [NUM_WIN_CELLS];
    t_column          cell_out [NUM_WIN_CELLS];
    t_column          tl;
    t_column          tc;
    t_column          tr;
    t_mac_in          mac_in;
    logic             mac_ready;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign geom_wr = cfg_wr && ((cfg_idx == CFG_IMAGE_WIDTH) || (cfg_idx == CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RST;
            r_image_height  <= HEIGHT_RST;
            r_center_weight <= CENTER_RST;
            r_edge_weight   <= EDGE_RST;
            r_corner_weight <= CORNER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_IMAGE_WIDTH:   r_image_width   <= pwdata[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= pwdata[CFG_DIM_W-1:0];
                CFG_CENTER_WEIGHT: r_center_weight <= pwdata[WEIGHT_W-1:0];
                CFG_EDGE_WEIGHT:   r_edge_weight   <= pwdata[WEIGHT_W-1:0];
                CFG_CORNER_WEIGHT: r_corner_weight <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_IMAGE_WIDTH:   prdata = APB_DW'(r_image_width);
            CFG_IMAGE_HEIGHT:  prdata = APB_DW'(r_image_height);
            CFG_CENTER_WEIGHT: prdata = APB_DW'(r_center_weight);
            CFG_EDGE_WEIGHT:   prdata = APB_DW'(r_edge_weight);
            CFG_CORNER_WEIGHT: prdata = APB_DW'(r_corner_weight);
            default:           prdata = '0;
        endcase
    end

    // ---------------- effective geometry ----------------
    assign w_raw = WXW'(r_image_width);
    assign h_raw = HXW'(r_image_height);

    always_comb begin
        if (w_raw == '0) begin
            w_eff = WCW'(1);
        end else if (w_raw > WXW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(w_raw);
        end
        if (h_raw == '0) begin
            h_eff = RW'(1);
        end else if (h_raw > HXW'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(h_raw);
        end
    end

    // ---------------- accept stage ----------------
    assign accept = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;
    assign x_val = i_pix.mode ? '0 : i_pix.pixel_in;

    always_comb begin
        col_zero     = (r_col == '0);
        // e1: first column closes the previous row's last pixel
        e1           = col_zero && (r_row >= RW'(2)) && (r_row <= h_eff + RW'(1));
        e2           = !col_zero && (r_row >= RW'(1)) && (r_row <= h_eff);
        tap.emit     = e1 || e2;
        tap.right_en = e2;
        tap.left_en  = e1 ? (w_eff >= WCW'(2)) : (r_col >= CW'(2));
        tap.top_en   = e1 ? (r_row != RW'(2)) : (r_row != RW'(1));
        tap.bot_en   = e1 ? (r_row <= h_eff) : (r_row < h_eff);
        tap.last     = e1 && (r_row == h_eff + RW'(1));

        col_inc = WCW'(r_col) + WCW'(1);
        row_inc = r_row + RW'(1);
        if (tap.last) begin
            n_row = '0;
            n_col = '0;
        end else if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc > h_eff + RW'(1)) ? '0 : row_inc;
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (geom_wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    lsf_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (b_fire),
        .i_waddr (r_b_col),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // ---------------- window stage ----------------
    assign b_adv    = !r_b_ctl.emit || mac_ready;
    assign b_fire   = r_b_valid && b_adv;
    assign in_ready = !r_b_valid || b_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_ready) begin
            r_b_valid <= accept;
        end
    end

    // same column written by the departing transaction: RAM read returns old data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_x        <= x_val;
            r_b_col      <= r_col;
            r_b_ctl      <= tap;
            r_b_fwd      <= b_fire && (r_b_col == r_col);
            r_b_fwd_data <= wr_data;
        end
    end

    assign ls_word   = r_b_fwd ? r_b_fwd_data : ram_q;
    assign wr_data   = {ls_word[PIX_W-1:0], r_b_x};
    assign col_n.top = ls_word[LS_W-1:PIX_W];
    assign col_n.mid = ls_word[PIX_W-1:0];
    assign col_n.bot = r_b_x;

    for (genvar k = 0; k < NUM_WIN_CELLS; k++) begin : g_cell
        if (k == NUM_WIN_CELLS - 1) begin : g_head
            assign cell_in[k] = col_n;
        end else begin : g_link
            assign cell_in[k] = cell_out[k+1];
        end
        lsf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (b_fire),
            .i_col   (cell_in[k]),
            .o_col   (cell_out[k])
        );
    end

    always_comb begin
        tl = r_b_ctl.left_en  ? cell_out[0] : '0;
        tc = cell_out[NUM_WIN_CELLS-1];
        tr = r_b_ctl.right_en ? col_n : '0;
        if (!r_b_ctl.top_en) begin
            tl.top = '0;
            tc.top = '0;
            tr.top = '0;
        end
        if (!r_b_ctl.bot_en) begin
            tl.bot = '0;
            tc.bot = '0;
            tr.bot = '0;
        end
        mac_in.center     = tc.mid;
        mac_in.edge_sum   = SUM_W'(tc.top) + SUM_W'(tl.mid) + SUM_W'(tr.mid) + SUM_W'(tc.bot);
        mac_in.corner_sum = SUM_W'(tl.top) + SUM_W'(tr.top) + SUM_W'(tl.bot) + SUM_W'(tr.bot);
        mac_in.last       = r_b_ctl.last;
    end

    lsf_mac u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_b_valid && r_b_ctl.emit),
        .o_ready         (mac_ready),
        .i_data          (mac_in),
        .i_center_weight (r_center_weight),
        .i_edge_weight   (r_edge_weight),
        .i_corner_weight (r_corner_weight),
        .o_pix           (o_pix)
    );
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lsf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 100;
    localparam int LARGE_TAIL    = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_filt_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              sink_ready = 1'b0;

    lsf_in_if  pix_in_ch ();
    lsf_out_if pix_out_ch ();

    assign pix_out_ch.ready = sink_ready;

    log_stencil_filter_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_ch),
        .o_pix   (pix_out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter state as the block should hold it
    logic [CFG_DIM_W-1:0] cfg_width  = WIDTH_RST;
    logic [CFG_DIM_W-1:0] cfg_height = HEIGHT_RST;
    logic [WEIGHT_W-1:0]  wt_center  = CENTER_RST;
    logic [WEIGHT_W-1:0]  wt_edge    = EDGE_RST;
    logic [WEIGHT_W-1:0]  wt_corner  = CORNER_RST;
    logic [PIX_W-1:0]     upper_rows  [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0]     middle_rows [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0]     win [3][3] = '{default: '0};
    int unsigned          in_row = 0;
    int unsigned          in_col = 0;
    t_filt_pixel          expected_pixels [$];

    int error_count  = 0;
    int items_sent   = 0;
    int cycle_count  = 0;
    int src_idle_pct = 26;
    int snk_idle_pct = 71;
    int hold_asked   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int unsigned frame_items();
        int unsigned w;
        int unsigned h;
        w = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        return w * h + w + 1;
    endfunction

    function automatic logic [PIX_W-1:0] weighted_sum(input int unsigned t[3][3]);
        longint unsigned acc;
        acc = 64'(t[1][1]) * wt_center
            + 64'(t[0][1] + t[1][0] + t[1][2] + t[2][1]) * wt_edge
            + 64'(t[0][0] + t[0][2] + t[2][0] + t[2][2]) * wt_corner;
        acc = acc >> FRAC_W;
        return (acc > 255) ? 8'hFF : acc[PIX_W-1:0];
    endfunction

    task automatic filter_accept(input logic drain, input logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned row;
        int unsigned col;
        int unsigned r;
        int unsigned a;
        int unsigned t[3][3];
        logic [PIX_W-1:0] x;
        bit emit;
        bit last;
        t_filt_pixel res;
        w = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        row = in_row;
        col = in_col;
        x = drain ? '0 : pix;
        emit = 0;
        last = 0;
        r = 0;
        t = '{default: 0};
        // first column of a row closes the last column of the row two above
        if (col == 0 && row >= 2 && row - 2 < h) begin
            r = row - 2;
            for (a = 0; a < 3; a++) begin
                t[a][0] = (w >= 2) ? win[a][1] : 0;
                t[a][1] = win[a][2];
                t[a][2] = 0;
            end
            emit = 1;
            last = (r == h - 1);
        end
        for (a = 0; a < 3; a++) begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = upper_rows[col];
        win[1][2] = middle_rows[col];
        win[2][2] = x;
        upper_rows[col] = middle_rows[col];
        middle_rows[col] = x;
        if (col >= 1 && row >= 1 && row - 1 < h) begin
            r = row - 1;
            for (a = 0; a < 3; a++) begin
                t[a][0] = (col >= 2) ? win[a][0] : 0;
                t[a][1] = win[a][1];
                t[a][2] = win[a][2];
            end
            emit = 1;
        end
        if (emit) begin
            for (a = 0; a < 3; a++) begin
                if (r == 0)
                    t[0][a] = 0;
                if (r + 1 >= h)
                    t[2][a] = 0;
            end
            res.pixel = weighted_sum(t);
            res.frame_end = last;
            expected_pixels.push_back(res);
        end
        if (last) begin
            in_row = 0;
            in_col = 0;
        end else begin
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
            in_row = row;
            in_col = col;
        end
    endtask

    task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_filt_pixel want;
        if (i_rst_n && pix_out_ch.valid && sink_ready) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual pixel_out %0d",
                         $time, pix_out_ch.pixel_out);
            end else begin
                want = expected_pixels.pop_front();
                if (pix_out_ch.pixel_out !== want.pixel)
                    flag_error("pixel_out", want.pixel, pix_out_ch.pixel_out);
                if (pix_out_ch.frame_end !== want.frame_end)
                    flag_error("frame_end", want.frame_end, pix_out_ch.frame_end);
            end
        end
    end

    // output back-pressure: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            sink_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_transfer(input logic wr, input t_cfg_idx idx, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input t_cfg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        apb_transfer(1'b0, idx, '0, got);
        if (got !== want)
            flag_error($sformatf("%s readback", idx.name()), want, got);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] value);
        logic [31:0] unused;
        logic [31:0] stored;
        apb_transfer(1'b1, idx, value, unused);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                cfg_width = value[CFG_DIM_W-1:0];
                in_row = 0;
                in_col = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                cfg_height = value[CFG_DIM_W-1:0];
                in_row = 0;
                in_col = 0;
            end
            CFG_CENTER_WEIGHT: wt_center = value[WEIGHT_W-1:0];
            CFG_EDGE_WEIGHT:   wt_edge   = value[WEIGHT_W-1:0];
            CFG_CORNER_WEIGHT: wt_corner = value[WEIGHT_W-1:0];
            default: ;
        endcase
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT)
            stored = 32'(value[CFG_DIM_W-1:0]);
        else
            stored = 32'(value[WEIGHT_W-1:0]);
        check_register(idx, stored);
    endtask

    task automatic set_geometry(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h);
        cfg_write(CFG_IMAGE_WIDTH, 32'(w));
        cfg_write(CFG_IMAGE_HEIGHT, 32'(h));
    endtask

    task automatic set_weights(input logic [WEIGHT_W-1:0] c, input logic [WEIGHT_W-1:0] e,
                               input logic [WEIGHT_W-1:0] k);
        cfg_write(CFG_CENTER_WEIGHT, 32'(c));
        cfg_write(CFG_EDGE_WEIGHT, 32'(e));
        cfg_write(CFG_CORNER_WEIGHT, 32'(k));
    endtask

    task automatic push_pixel(input logic drain, input logic [PIX_W-1:0] pix);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            pix_in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        pix_in_ch.valid    <= 1'b1;
        pix_in_ch.mode     <= drain;
        pix_in_ch.pixel_in <= pix;
        do @(posedge i_clk); while (pix_in_ch.ready !== 1'b1);
        filter_accept(drain, pix);
        items_sent++;
    endtask

    task automatic drain_results();
        pix_in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom_range(65535));
            default: return WEIGHT_W'($urandom_range(4000, 12000));
        endcase
    endfunction

    function automatic logic [CFG_DIM_W-1:0] pick_dim(input int unsigned hi);
        case ($urandom_range(9))
            0: return '0;
            1: return 1;
            2: return 2;
            default: return CFG_DIM_W'($urandom_range(3, hi));
        endcase
    endfunction

    // items from raster index first on; the tail past the frame is mostly drain
    task automatic send_frame_items(input int unsigned first, input int unsigned count);
        int unsigned w;
        int unsigned h;
        int unsigned k;
        logic drain;
        w = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        for (k = first; k < first + count; k++) begin
            if (k < w * h)
                drain = ($urandom_range(15) == 0);
            else
                drain = ($urandom_range(7) != 0);
            push_pixel(drain, pick_pixel());
        end
    endtask

    task automatic test_register_defaults();
        check_register(CFG_IMAGE_WIDTH, 32'(WIDTH_RST));
        check_register(CFG_IMAGE_HEIGHT, 32'(HEIGHT_RST));
        check_register(CFG_CENTER_WEIGHT, 32'(CENTER_RST));
        check_register(CFG_EDGE_WEIGHT, 32'(EDGE_RST));
        check_register(CFG_CORNER_WEIGHT, 32'(CORNER_RST));
    endtask

    task automatic test_reset_geometry();
        send_frame_items(0, int'(WIDTH_RST) + 8);
    endtask

    task automatic test_kernel_extremes();
        int unsigned k;
        int unsigned n;
        settle();
        set_geometry(3, 3);
        set_weights('1, '1, '1);
        n = frame_items();
        for (k = 0; k < n; k++)
            push_pixel(k >= 9, '1);
        settle();
        set_weights('0, '0, '0);
        send_frame_items(0, frame_items());
        settle();
        set_weights('1, '0, '0);
        send_frame_items(0, frame_items());
    endtask

    task automatic test_tiny_frames();
        settle();
        set_weights(CENTER_RST, EDGE_RST, CORNER_RST);
        set_geometry(0, 0);
        send_frame_items(0, frame_items());
        send_frame_items(0, frame_items());
        settle();
        set_geometry(1, 3);
        send_frame_items(0, frame_items());
        settle();
        set_geometry(4, 1);
        send_frame_items(0, frame_items());
        settle();
        set_geometry(2, 2);
        send_frame_items(0, frame_items());
    endtask

    task automatic test_item_kinds();
        int unsigned k;
        int unsigned n;
        settle();
        set_geometry(4, 3);
        n = frame_items();
        for (k = 0; k < n; k++)
            push_pixel(1'($urandom_range(1)), pick_pixel());
    endtask

    task automatic test_restart_midframe();
        settle();
        set_geometry(4, 3);
        send_frame_items(0, 9);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, 4);
        send_frame_items(0, frame_items());
        send_frame_items(0, 7);
        settle();
        cfg_write(CFG_CENTER_WEIGHT, 20000);
        cfg_write(CFG_EDGE_WEIGHT, 3000);
        send_frame_items(7, frame_items() - 7);
        send_frame_items(0, 11);
        settle();
        cfg_write(CFG_IMAGE_HEIGHT, 3);
        send_frame_items(0, frame_items());
    endtask

    task automatic test_receiver_hold();
        settle();
        set_geometry(6, 5);
        src_idle_pct = 0;
        hold_asked <= hold_asked + 1;
        send_frame_items(0, frame_items());
        src_idle_pct = 26;
    endtask

    task automatic test_sender_pause();
        settle();
        set_geometry(5, 4);
        send_frame_items(0, 10);
        drain_results();
        send_frame_items(10, frame_items() - 10);
    endtask

    task automatic test_random_frames();
        int unsigned first_item;
        int unsigned done;
        int unsigned total;
        bit restart_due;
        first_item = items_sent;
        restart_due = 1;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            done = items_sent - first_item;
            if (done < RANDOM_ITEMS / 3) begin
                src_idle_pct = 26;
                snk_idle_pct = 71;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 71;
                snk_idle_pct = 26;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (restart_due || $urandom_range(2) == 0) begin
                settle();
                set_geometry(pick_dim(5), pick_dim(4));
                if ($urandom_range(1) == 0)
                    set_weights(pick_weight(), pick_weight(), pick_weight());
                restart_due = 0;
            end
            total = frame_items();
            if ($urandom_range(6) == 0) begin
                // broken frame, abandoned by the next geometry write
                send_frame_items(0, $urandom_range(1, total - 1));
                restart_due = 1;
            end else begin
                send_frame_items(0, total);
            end
        end
    endtask

    task automatic test_large_geometry();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        settle();
        set_weights(CENTER_RST, EDGE_RST, CORNER_RST);
        set_geometry('1, '1);
        // partial frame, just past the row wrap at the clamped width
        send_frame_items(0, MAX_WIDTH_DEF + LARGE_TAIL);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_in_ch.valid    <= 1'b0;
        pix_in_ch.mode     <= 1'b0;
        pix_in_ch.pixel_in <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_defaults();
        test_reset_geometry();
        test_kernel_extremes();
        test_tiny_frames();
        test_item_kinds();
        test_restart_midframe();
        test_receiver_hold();
        test_sender_pause();
        test_random_frames();
        test_large_geometry();

        settle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lsf_pkg.sv
rtl/core/lsf_in_if.sv
rtl/core/lsf_out_if.sv
rtl/core/lsf_ram.sv
rtl/core/lsf_cell.sv
rtl/core/lsf_mac.sv
rtl/core/log_stencil_filter_3x3.sv
tb/sv/testbench.sv
